[hw/rtl/spq_pkg.sv]
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_DEQUEUE = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] task_handle;
		logic [7:0] task_priority;
	} spq_req_t;

	typedef struct packed {
		logic       was_empty;
		logic       overflow;
		logic       got_task;
		logic [7:0] out_handle;
		logic [7:0] out_priority;
	} spq_rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} spq_cmd_t;

endpackage

[hw/rtl/spq_ctrl.sv]
module spq_ctrl import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output spq_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_EXEC);
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && start;
		cmd.exec = (state_q == ST_EXEC);
	end

	assign busy = (state_q == ST_EXEC);
	assign done = done_q;

endmodule

[hw/rtl/spq_datapath.sv]
module spq_datapath import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  spq_cmd_t cmd,
	input  spq_req_t request,
	output spq_rsp_t result
);

	spq_req_t         req_q;
	spq_rsp_t         rsp_q;
	logic [7:0]       hnd_q [CAPACITY];
	logic [7:0]       pri_q [CAPACITY];
	logic [CNT_W-1:0] count_q;

	logic [CAPACITY-1:0] ge;
	logic [7:0]          hnd_d [CAPACITY];
	logic [7:0]          pri_d [CAPACITY];
	spq_rsp_t            rsp_d;
	logic                is_empty;
	logic                is_full;

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_W'(CAPACITY));

	// Cells whose stored priority is the same or higher stay put; the list is
	// sorted, so these form a prefix and the new entry lands right after it.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ge[i] = (CNT_W'(i) < count_q) && (pri_q[i] >= req_q.task_priority);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			hnd_d[i] = hnd_q[i];
			pri_d[i] = pri_q[i];
			if (req_q.action == ACT_DEQUEUE) begin
				if (i < CAPACITY - 1) begin
					hnd_d[i] = hnd_q[(i == CAPACITY - 1) ? i : i + 1];
					pri_d[i] = pri_q[(i == CAPACITY - 1) ? i : i + 1];
				end
			end else if (!ge[i]) begin
				if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
					hnd_d[i] = req_q.task_handle;
					pri_d[i] = req_q.task_priority;
				end else begin
					hnd_d[i] = hnd_q[(i == 0) ? 0 : i - 1];
					pri_d[i] = pri_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	always_comb begin
		rsp_d = '0;
		if (req_q.action == ACT_ENQUEUE) begin
			rsp_d.overflow  = is_full;
			rsp_d.was_empty = is_empty;
		end else if (!is_empty) begin
			rsp_d.got_task     = 1'b1;
			rsp_d.out_handle   = hnd_q[0];
			rsp_d.out_priority = pri_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= request;
		if (cmd.exec) begin
			rsp_q <= rsp_d;
			if ((req_q.action == ACT_ENQUEUE && !is_full) ||
			    (req_q.action == ACT_DEQUEUE && !is_empty)) begin
				for (int i = 0; i < CAPACITY; i++) begin
					hnd_q[i] <= hnd_d[i];
					pri_q[i] <= pri_d[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (req_q.action == ACT_ENQUEUE && !is_full) count_q <= count_q + 1'b1;
			else if (req_q.action == ACT_DEQUEUE && !is_empty) count_q <= count_q - 1'b1;
		end
	end

	assign result = rsp_q;

endmodule

[hw/rtl/stable_priority_queue_top.sv]
// Each request accepted while idle is captured, then executed; its result is
// registered onto the result ports, with done high, for exactly one cycle.
// A start while busy is ignored. Busy is high in the execute cycle, in which
// the whole chain shifts or inserts at once, unless full or empty blocks it.
// Reset (arst_n low, asynchronous) empties the queue; cell contents are not
// cleared. The receiver cannot stall: each result is taken as it appears.
module stable_priority_queue_top import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  spq_req_t request,
	output logic     done,
	output spq_rsp_t result
);

	spq_cmd_t cmd;

	// Sequence each request: capture it, then execute on the cell chain.
	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Hold the sorted cells, the fill count and the registered result.
	spq_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.result  (result)
	);

endmodule
